// ----- design/rmd_pkg.sv -----
// Shared types and constants for the rotator motor drive.
`timescale 1ns / 1ps
package rmd_pkg;

  localparam int unsigned ErrW   = 17;
  localparam int unsigned TimeW  = 32;
  localparam int unsigned LevelW = 8;
  localparam int unsigned GainW  = 16;
  localparam int unsigned WeightW = 9;
  localparam int unsigned ModeW  = 2;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned InDataW = 56;
  localparam int unsigned OutDataW = 16;

  localparam int unsigned ProdW  = 33;
  localparam int unsigned AcW    = 26;
  localparam int unsigned ClampW = 24;

  localparam logic [ProdW-1:0] DutyClamp = ProdW'(255 * 65536);
  localparam logic [AcW-1:0]   MaxErrQ16 = AcW'(20 * 65536);
  localparam logic [AcW-1:0]   OneDegQ16 = AcW'(65536);
  localparam logic [ErrW-1:0]  DeadZone  = ErrW'(128);
  localparam logic [TimeW:0]   OnTimeMs  = (TimeW + 1)'(20);
  localparam logic [LevelW-1:0] LevelHigh = 8'hFF;
  localparam logic [LevelW-1:0] LevelLow  = 8'h00;

  localparam logic [GainW-1:0]   GainReset   = 16'd256;
  localparam logic [WeightW-1:0] WeightReset = 9'd256;

  typedef enum logic [ModeW-1:0] {
    MODE_PWM_DIR = 2'd0,
    MODE_FWD_REV = 2'd1,
    MODE_AC      = 2'd2,
    MODE_UNUSED  = 2'd3
  } mode_t;

  typedef enum logic [CfgIdxW-1:0] {
    REG_MOTOR_MODE    = 2'd0,
    REG_LOOP_GAIN     = 2'd1,
    REG_FILTER_WEIGHT = 2'd2,
    REG_NONE          = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_MUL1 = 2'd1,
    ST_MUL2 = 2'd2,
    ST_UPD  = 2'd3
  } state_t;

  typedef struct packed {
    logic load;
    logic mul1;
    logic mul2;
    logic update;
  } cmd_t;

  typedef struct packed {
    logic out_busy;
  } status_t;

endpackage

// ----- design/rmd_ctrl.sv -----
// Sequencer that steps one beat through load, two multiply stages and the level update.
`timescale 1ns / 1ps
module rmd_ctrl import rmd_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_tvalid,
  output logic    in_tready,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_MUL1;
        end
      end
      ST_MUL1: begin
        cmd.mul1  = 1'b1;
        state_nxt = ST_MUL2;
      end
      ST_MUL2: begin
        cmd.mul2  = 1'b1;
        state_nxt = ST_UPD;
      end
      ST_UPD: begin
        if (!status.out_busy) begin
          cmd.update = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

// ----- design/rmd_datapath.sv -----
// Datapath: error magnitude, gain and weight products, off time and pin level state.
`timescale 1ns / 1ps
module rmd_datapath import rmd_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  cmd_t                cmd,
  output status_t             status,
  input  logic [ErrW-1:0]     angle_error,
  input  logic [TimeW-1:0]    now_ms,
  input  mode_t               motor_mode,
  input  logic [GainW-1:0]    loop_gain,
  input  logic [WeightW-1:0]  filter_weight,
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [LevelW-1:0]   fwd_duty,
  output logic [LevelW-1:0]   rev_duty
);

  logic [ErrW-1:0]   angle_r;
  logic [TimeW-1:0]  now_r;
  logic              neg_r;
  logic [ErrW-1:0]   mag_r;
  logic [ProdW-1:0]  m_r;
  logic [AcW-1:0]    a_r;
  logic [ProdW-1:0]  s_r;
  logic [LevelW-1:0] off_r;
  logic [TimeW-1:0]  elapsed_r;
  logic              a_small_r;

  logic [LevelW-1:0] fwd_level_r, fwd_level_nxt;
  logic [LevelW-1:0] rev_level_r, rev_level_nxt;
  logic [TimeW-1:0]  pulse_start_r, pulse_start_nxt;
  logic              out_valid_r;

  logic              neg;
  logic [ErrW-1:0]   mag;
  logic [ClampW-1:0] m_clamped;
  logic [AcW-1:0]    ac_diff;
  logic [ClampW-1:0] ac_scaled;
  logic [LevelW-1:0] off_nxt;
  logic [LevelW-1:0] duty;
  logic              pos;
  logic              dead;

  assign neg = angle_r[ErrW-1];
  assign mag = neg ? (~angle_r + ErrW'(1)) : angle_r;

  assign m_clamped = (m_r > DutyClamp) ? DutyClamp[ClampW-1:0] : m_r[ClampW-1:0];
  assign ac_diff   = MaxErrQ16 - a_r;
  assign ac_scaled = ClampW'({ac_diff, 2'b00}) + ClampW'(ac_diff);
  assign off_nxt   = (a_r > MaxErrQ16) ? LevelLow : ac_scaled[ClampW-1:ClampW-LevelW];

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      angle_r <= angle_error;
      now_r   <= now_ms;
    end
    if (cmd.mul1) begin
      neg_r <= neg;
      mag_r <= mag;
      m_r   <= ProdW'(mag) * ProdW'(loop_gain);
      a_r   <= AcW'(mag) * AcW'(filter_weight);
    end
    if (cmd.mul2) begin
      s_r       <= ProdW'(m_clamped) * ProdW'(filter_weight);
      off_r     <= off_nxt;
      elapsed_r <= now_r - pulse_start_r;
      a_small_r <= a_r < OneDegQ16;
    end
  end

  assign duty = s_r[ProdW-1] ? LevelHigh : s_r[ProdW-2:ProdW-1-LevelW];
  assign pos  = !neg_r && (mag_r != '0) && (s_r != '0);
  assign dead = mag_r < DeadZone;

  always_comb begin
    fwd_level_nxt   = fwd_level_r;
    rev_level_nxt   = rev_level_r;
    pulse_start_nxt = pulse_start_r;
    case (motor_mode)
      MODE_PWM_DIR: begin
        fwd_level_nxt = dead ? LevelLow : duty;
        rev_level_nxt = pos ? LevelHigh : LevelLow;
      end
      MODE_FWD_REV: begin
        if (dead) begin
          fwd_level_nxt = LevelLow;
          rev_level_nxt = LevelLow;
        end else if (pos) begin
          fwd_level_nxt = duty;
          rev_level_nxt = LevelLow;
        end else begin
          fwd_level_nxt = LevelLow;
          rev_level_nxt = duty;
        end
      end
      MODE_AC: begin
        if (a_small_r) begin
          fwd_level_nxt = LevelLow;
          rev_level_nxt = LevelLow;
        end else begin
          if (elapsed_r > TimeW'(off_r)) begin
            fwd_level_nxt = LevelLow;
            rev_level_nxt = LevelLow;
          end
          if ({1'b0, elapsed_r} > ((TimeW + 1)'(off_r) + OnTimeMs)) begin
            if (neg_r) begin
              rev_level_nxt = LevelHigh;
            end else begin
              fwd_level_nxt = LevelHigh;
            end
            pulse_start_nxt = now_r;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_level_r   <= LevelLow;
      rev_level_r   <= LevelLow;
      pulse_start_r <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cmd.update) begin
        fwd_level_r   <= fwd_level_nxt;
        rev_level_r   <= rev_level_nxt;
        pulse_start_r <= pulse_start_nxt;
        out_valid_r   <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign status.out_busy = out_valid_r && !out_tready;
  assign out_tvalid      = out_valid_r;
  assign fwd_duty        = fwd_level_r;
  assign rev_duty        = rev_level_r;

endmodule

// ----- design/rotator_motor_drive.sv -----
// Top level of the rotator motor drive: configuration registers, sequencer and datapath.
`timescale 1ns / 1ps
// Each input beat carries a signed pointing error in 1/256 degree and the current
// millisecond time; one output beat follows with the forward and reverse pin levels.
// An item is accepted and captured, then the error times gain and weight products
// are formed, then the clamped duty times weight product and the pulse off time,
// and last the pin levels are updated. The next beat is taken in the cycle after
// the update, so the block takes no new item before the last one is through; a
// result still waiting holds the update cycle until it is taken. Configuration
// writes must only occur while no item is in flight.
module rotator_motor_drive import rmd_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [InDataW-1:0]  in_tdata,   // angle_error[16:0], now_ms[48:17], zero pad
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [OutDataW-1:0] out_tdata,  // fwd_duty[7:0], rev_duty[15:8]
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data
);

  mode_t               motor_mode_r;
  logic [GainW-1:0]    loop_gain_r;
  logic [WeightW-1:0]  filter_weight_r;
  cmd_t                cmd;
  status_t             status;
  logic [LevelW-1:0]   fwd_duty;
  logic [LevelW-1:0]   rev_duty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      motor_mode_r    <= MODE_PWM_DIR;
      loop_gain_r     <= GainReset;
      filter_weight_r <= WeightReset;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_MOTOR_MODE:    motor_mode_r    <= mode_t'(cfg_data[ModeW-1:0]);
        REG_LOOP_GAIN:     loop_gain_r     <= cfg_data[GainW-1:0];
        REG_FILTER_WEIGHT: filter_weight_r <= cfg_data[WeightW-1:0];
        default: begin
        end
      endcase
    end
  end

  rmd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  rmd_datapath u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .status        (status),
    .angle_error   (in_tdata[ErrW-1:0]),
    .now_ms        (in_tdata[ErrW+TimeW-1:ErrW]),
    .motor_mode    (motor_mode_r),
    .loop_gain     (loop_gain_r),
    .filter_weight (filter_weight_r),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .fwd_duty      (fwd_duty),
    .rev_duty      (rev_duty)
  );

  assign out_tdata = {rev_duty, fwd_duty};

endmodule

// ----- dv/rotator_motor_drive_checker.sv -----
// Checker for the rotator motor drive: tracks the registers, predicts pin levels and compares.
`timescale 1ns / 1ps
module rotator_motor_drive_checker import rmd_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  input  logic                in_tready,
  input  logic [InDataW-1:0]  in_tdata,
  input  logic                out_tvalid,
  input  logic                out_tready,
  input  logic [OutDataW-1:0] out_tdata,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data,
  output logic [31:0]         fail_count,
  output logic [31:0]         outstanding,
  output logic [31:0]         results_checked
);

  localparam logic [32:0] DUTY_CEIL  = 33'(255 * 65536);
  localparam int unsigned DEAD_BAND  = 128;
  localparam int unsigned ONE_DEGREE = 65536;
  localparam int unsigned ERR_LIMIT  = 20 * 65536;
  localparam int unsigned PULSE_MS   = 20;
  localparam int unsigned OFF_SLOPE  = 5;

  typedef struct packed {
    logic [LevelW-1:0] rev;
    logic [LevelW-1:0] fwd;
  } pins_t;

  mode_t              mode_q;
  logic [GainW-1:0]   gain_q;
  logic [WeightW-1:0] weight_q;
  logic [LevelW-1:0]  fwd_q;
  logic [LevelW-1:0]  rev_q;
  logic [TimeW-1:0]   pulse_start_q;
  pins_t              expected_pins[$];
  pins_t              want;

  task automatic report_mismatch(input string msg);
    if (fail_count < 50) begin
      $display("MISMATCH at %0t ns: %s", $time, msg);
    end
    fail_count++;
  endtask

  task automatic drive_pins(input logic [ErrW-1:0] err, input logic [TimeW-1:0] now);
    logic              neg;
    logic [ErrW-1:0]   mag;
    logic [32:0]       prod;
    logic [41:0]       scaled;
    logic [LevelW-1:0] duty;
    logic              pos;
    logic [25:0]       ac_err;
    logic [31:0]       off_ms;
    logic [31:0]       elapsed;
    neg = err[ErrW-1];
    mag = neg ? -err : err;
    case (mode_q)
      MODE_PWM_DIR, MODE_FWD_REV: begin
        prod = 33'(mag) * 33'(gain_q);
        if (prod > DUTY_CEIL) begin
          prod = DUTY_CEIL;
        end
        scaled = 42'(prod) * 42'(weight_q);
        duty = (scaled[41:24] > 18'd255) ? 8'hFF : scaled[31:24];
        pos = !neg && (mag != '0) && (scaled != '0);
        if (mode_q == MODE_PWM_DIR) begin
          fwd_q = (mag < DEAD_BAND) ? 8'h00 : duty;
          rev_q = pos ? 8'hFF : 8'h00;
        end else if (mag < DEAD_BAND) begin
          fwd_q = 8'h00;
          rev_q = 8'h00;
        end else if (pos) begin
          fwd_q = duty;
          rev_q = 8'h00;
        end else begin
          fwd_q = 8'h00;
          rev_q = duty;
        end
      end
      MODE_AC: begin
        ac_err = 26'(mag) * 26'(weight_q);
        if (ac_err < ONE_DEGREE) begin
          fwd_q = 8'h00;
          rev_q = 8'h00;
        end else begin
          if (ac_err > ERR_LIMIT) begin
            off_ms = '0;
          end else begin
            off_ms = (32'(OFF_SLOPE) * (32'(ERR_LIMIT) - 32'(ac_err))) >> 16;
          end
          elapsed = now - pulse_start_q;
          if (elapsed > off_ms) begin
            fwd_q = 8'h00;
            rev_q = 8'h00;
          end
          if ({1'b0, elapsed} > {1'b0, off_ms} + 33'(PULSE_MS)) begin
            if (neg) begin
              rev_q = 8'hFF;
            end else begin
              fwd_q = 8'hFF;
            end
            pulse_start_q = now;
          end
        end
      end
      default: begin
      end
    endcase
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      mode_q = MODE_PWM_DIR;
      gain_q = 16'd256;
      weight_q = 9'd256;
      fwd_q = '0;
      rev_q = '0;
      pulse_start_q = '0;
      expected_pins.delete();
      fail_count = 0;
      results_checked = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_pins.size() == 0) begin
          report_mismatch($sformatf("result beat %h arrived with no item waiting", out_tdata));
        end else begin
          want = expected_pins.pop_front();
          results_checked++;
          if (out_tdata[7:0] !== want.fwd) begin
            report_mismatch($sformatf("fwd_duty got %h, want %h", out_tdata[7:0], want.fwd));
          end
          if (out_tdata[15:8] !== want.rev) begin
            report_mismatch($sformatf("rev_duty got %h, want %h", out_tdata[15:8], want.rev));
          end
        end
      end
      if (in_tvalid && in_tready) begin
        drive_pins(in_tdata[ErrW-1:0], in_tdata[ErrW+TimeW-1:ErrW]);
        expected_pins.push_back({rev_q, fwd_q});
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_MOTOR_MODE:    mode_q = mode_t'(cfg_data[ModeW-1:0]);
          REG_LOOP_GAIN:     gain_q = cfg_data[GainW-1:0];
          REG_FILTER_WEIGHT: weight_q = cfg_data[WeightW-1:0];
          default: begin
          end
        endcase
      end
    end
    outstanding <= expected_pins.size();
  end

endmodule

// ----- dv/rotator_motor_drive_tb.sv -----
// Testbench top for the rotator motor drive: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module rotator_motor_drive_tb;
  import rmd_pkg::*;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_tvalid = 1'b0;
  logic                in_tready;
  logic [InDataW-1:0]  in_tdata = '0;   // angle_error[16:0], now_ms[48:17], zero pad
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [OutDataW-1:0] out_tdata;       // fwd_duty[7:0], rev_duty[15:8]
  logic                cfg_we = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;

  logic [31:0] fail_count;
  logic [31:0] outstanding;
  logic [31:0] results_checked;

  int unsigned beats_sent = 0;
  int unsigned settings_used = 0;
  logic [31:0] clock_ms = '0;
  int          ready_kind = 0;
  int          ready_left = 0;
  int unsigned ready_tick = 0;

  rotator_motor_drive i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  rotator_motor_drive_checker i_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .fail_count      (fail_count),
    .outstanding     (outstanding),
    .results_checked (results_checked)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("rotator_motor_drive_tb NOT OK");
    $finish;
  end

  // The receiver switches between always ready, light, heavy and periodic stalls.
  always @(negedge clk) begin
    if (ready_left == 0) begin
      ready_kind = $urandom_range(0, 3);
      ready_left = $urandom_range(20, 200);
    end
    ready_left--;
    ready_tick++;
    case (ready_kind)
      0: out_tready <= 1'b1;
      1: out_tready <= ($urandom_range(0, 3) != 0);
      2: out_tready <= ($urandom_range(0, 3) == 0);
      default: out_tready <= (ready_tick % 3 == 0);
    endcase
  end

  task automatic send_beat(input logic [ErrW-1:0] err, input logic [TimeW-1:0] now);
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata <= {(InDataW - ErrW - TimeW)'(0), now, err};
    do @(posedge clk); while (!in_tready);
    beats_sent++;
  endtask

  task automatic pause(input int cycles);
    @(negedge clk);
    in_tvalid <= 1'b0;
    repeat (cycles - 1) @(negedge clk);
  endtask

  task automatic wait_for_results();
    if (in_tvalid) begin
      pause(1);
    end
    do @(negedge clk); while (outstanding != 0);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [CfgDataW-1:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic configure(input mode_t mode, input logic [GainW-1:0] gain,
                           input logic [WeightW-1:0] weight);
    wait_for_results();
    write_reg(REG_MOTOR_MODE, CfgDataW'(mode));
    write_reg(REG_LOOP_GAIN, gain);
    write_reg(REG_FILTER_WEIGHT, CfgDataW'(weight));
    settings_used++;
  endtask

  function automatic logic [ErrW-1:0] pick_error();
    int v;
    case ($urandom_range(0, 9))
      0, 1, 2: v = int'($urandom_range(0, 92160)) - 46080;
      3: v = $urandom_range(120, 136);
      4: case ($urandom_range(0, 3))
           0: v = 46080;
           1: v = 0;
           2: v = 1;
           default: v = -46080;
         endcase
      5, 6: v = $urandom_range(0, 2000);
      default: v = $urandom_range(256, 6000);
    endcase
    if (v > 0 && $urandom_range(0, 1) == 1) begin
      v = -v;
    end
    return ErrW'(v);
  endfunction

  function automatic logic [TimeW-1:0] step_clock(input logic [TimeW-1:0] t);
    int k;
    k = $urandom_range(0, 19);
    if (k < 17) begin
      return t + $urandom_range(0, 30);
    end else if (k == 17) begin
      return t + $urandom_range(100, 1000);
    end else if (k == 18) begin
      return t;
    end
    return $urandom;
  endfunction

  initial begin
    int                 pwm_errs[9] = '{0, 127, 128, -128, -127, 46080, -46080, 1, -1};
    int                 bridge_errs[5] = '{0, 200, -200, 46080, -46080};
    int                 ac_errs[9] = '{256, 256, 256, 256, 256, -6000, 100, -46080, 46080};
    logic [TimeW-1:0]   ac_times[9] = '{32'd50, 32'd200, 32'd210, 32'd300, 32'd316, 32'd340,
                                        32'd350, 32'hFFFF_FFF0, 32'd5};
    mode_t              mode;
    logic [GainW-1:0]   gain;
    logic [WeightW-1:0] weight;
    int                 phase_len;
    int                 drain_at;
    int                 burst_left;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    // Reset values give direction mode with unity gain and weight.
    foreach (pwm_errs[i]) begin
      send_beat(ErrW'(pwm_errs[i]), $urandom);
    end
    configure(MODE_FWD_REV, 16'hFFFF, 9'd511);
    foreach (bridge_errs[i]) begin
      send_beat(ErrW'(bridge_errs[i]), $urandom);
    end
    configure(MODE_AC, 16'd256, 9'd256);
    foreach (ac_errs[i]) begin
      send_beat(ErrW'(ac_errs[i]), ac_times[i]);
    end
    clock_ms = ac_times[8];
    configure(MODE_UNUSED, 16'd256, 9'd128);
    send_beat(ErrW'(46080), clock_ms);
    send_beat(ErrW'(-300), clock_ms);

    for (int p = 0; p < 8; p++) begin
      case (p)
        0: begin
          mode = MODE_PWM_DIR;
          gain = GainW'($urandom_range(64, 1024));
          weight = 9'd256;
        end
        1: begin
          mode = MODE_FWD_REV;
          gain = 16'hFFFF;
          weight = WeightW'($urandom_range(0, 256));
        end
        2: begin
          mode = MODE_AC;
          gain = GainW'($urandom);
          weight = 9'd256;
        end
        3: begin mode = MODE_UNUSED; gain = 16'd0; weight = 9'd511; end
        4: begin
          mode = MODE_AC;
          gain = GainW'($urandom);
          weight = WeightW'($urandom_range(0, 511));
        end
        5: begin
          mode = MODE_PWM_DIR;
          gain = GainW'($urandom_range(1, 1024));
          weight = 9'd511;
        end
        6: begin mode = MODE_FWD_REV; gain = 16'd0; weight = 9'd0; end
        default: begin
          mode = MODE_AC;
          gain = 16'hFFFF;
          weight = WeightW'($urandom_range(200, 300));
        end
      endcase
      configure(mode, gain, weight);
      if (p == 3) begin
        write_reg(REG_NONE, 16'hFFFF);
      end
      phase_len = (mode == MODE_UNUSED || p == 6) ? 60 : 210;
      drain_at = $urandom_range(10, phase_len - 10);
      burst_left = 0;
      for (int i = 0; i < phase_len; i++) begin
        if (i == drain_at) begin
          wait_for_results();
        end
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 24);
          if ($urandom_range(0, 3) != 0) begin
            pause($urandom_range(1, 10));
          end
        end
        burst_left--;
        clock_ms = step_clock(clock_ms);
        send_beat(pick_error(), clock_ms);
      end
    end

    wait_for_results();
    $display("Run covered %0d beats over %0d register settings, %0d results checked,",
             beats_sent, settings_used, results_checked);
    $display("across all four modes, the dead zone, duty saturation and pulse timing.");
    if (fail_count == 0) begin
      $display("rotator_motor_drive_tb OK");
    end else begin
      $display("rotator_motor_drive_tb NOT OK");
    end
    $finish;
  end

endmodule
